// ===== sv/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types, fixed-point constants and tables for the plasma pixel
// generator pipeline.
// ----------------------------------------------------------------------------
package ppg_pkg;

   // Geometry
   localparam int IMAGE_SIZE = 512;
   localparam int PIX_W      = 9;
   localparam int COORD_W    = $clog2(((((1 << PIX_W) - 1) << 16) / IMAGE_SIZE) + 1);
   localparam int SUM_W      = 2 * COORD_W + 1;
   localparam int ROOT_W     = COORD_W + 1;

   // Time, phase and shade widths
   localparam int TIME_W  = 24;
   localparam int PHASE_W = 32;
   localparam int MAG_W   = 15;
   localparam int WAVE_W  = 16;
   localparam int SHADE_W = 15;
   localparam int NUM_WAVES = 4;

   localparam logic [COORD_W-1:0] HALF_Q16 = COORD_W'(32768);
   localparam logic [SHADE_W-1:0] ONE_Q14  = SHADE_W'(16384);

   // constant / (2 pi) in Q.16
   localparam logic [PHASE_W-1:0] KX_12  = PHASE_W'(125165);
   localparam logic [PHASE_W-1:0] KY_9   = PHASE_W'(93873);
   localparam logic [PHASE_W-1:0] KXY_7  = PHASE_W'(73013);
   localparam logic [PHASE_W-1:0] KR_24  = PHASE_W'(250329);
   localparam logic [PHASE_W-1:0] KT_1   = PHASE_W'(10430);
   localparam logic [PHASE_W-1:0] KT_07  = PHASE_W'(7301);
   localparam logic [PHASE_W-1:0] KT_13  = PHASE_W'(13559);
   localparam logic [PHASE_W-1:0] KT_2   = PHASE_W'(20861);

   // Quarter-wave sine, Q1.14, 32 segments
   localparam logic [MAG_W-1:0] QUARTER_SINE [33] = '{
      15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,
      15'd4756,  15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,
      15'd9102,  15'd9760,  15'd10394, 15'd11003, 15'd11585, 15'd12140,
      15'd12665, 15'd13160, 15'd13623, 15'd14053, 15'd14449, 15'd14811,
      15'd15137, 15'd15426, 15'd15679, 15'd15893, 15'd16069, 15'd16207,
      15'd16305, 15'd16364, 15'd16384
   };

   // Color endpoints, Q16 fractions of full scale: red, green, blue
   localparam logic [16:0] COOL_Q16 [3] = '{17'd2621,  17'd13107, 17'd42598};
   localparam logic [16:0] WARM_Q16 [3] = '{17'd65536, 17'd36045, 17'd9830};

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } ppg_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } ppg_rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] xq;
      logic [COORD_W-1:0] yq;
      logic [SUM_W-1:0]   dist_sq;
   } ppg_dist_type;

   typedef struct packed {
      logic [COORD_W-1:0] xq;
      logic [COORD_W-1:0] yq;
      logic [ROOT_W-1:0]  radius;
   } ppg_polar_type;

endpackage

// ===== sv/ppg_coord.sv =====
// ----------------------------------------------------------------------------
// ppg_coord
// Normalizes the pixel coordinate and forms the squared distance from the
// image center over three stages.
// ----------------------------------------------------------------------------
module ppg_coord import ppg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  ppg_req_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output ppg_dist_type out_data
);

   localparam int STAGES = 3;

   typedef struct packed {
      logic [COORD_W-1:0] xq;
      logic [COORD_W-1:0] yq;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
   } abs_type;

   typedef struct packed {
      logic [COORD_W-1:0]   xq;
      logic [COORD_W-1:0]   yq;
      logic [2*COORD_W-1:0] ax2;
      logic [2*COORD_W-1:0] ay2;
   } sqr_type;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES:0]   adv;
   abs_type           abs_ff, abs_in;
   sqr_type           sqr_ff, sqr_in;
   ppg_dist_type      dist_ff, dist_in;

   always_comb begin
      adv[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_comb begin
      abs_in.xq = COORD_W'({in_data.pixel_x, 16'b0} / IMAGE_SIZE);
      abs_in.yq = COORD_W'({in_data.pixel_y, 16'b0} / IMAGE_SIZE);
      abs_in.ax = (abs_in.xq >= HALF_Q16) ? abs_in.xq - HALF_Q16 : HALF_Q16 - abs_in.xq;
      abs_in.ay = (abs_in.yq >= HALF_Q16) ? abs_in.yq - HALF_Q16 : HALF_Q16 - abs_in.yq;

      sqr_in.xq  = abs_ff.xq;
      sqr_in.yq  = abs_ff.yq;
      sqr_in.ax2 = (2*COORD_W)'(abs_ff.ax) * (2*COORD_W)'(abs_ff.ax);
      sqr_in.ay2 = (2*COORD_W)'(abs_ff.ay) * (2*COORD_W)'(abs_ff.ay);

      dist_in.xq      = sqr_ff.xq;
      dist_in.yq      = sqr_ff.yq;
      dist_in.dist_sq = SUM_W'(sqr_ff.ax2) + SUM_W'(sqr_ff.ay2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (adv[0]) abs_ff  <= abs_in;
      if (adv[1]) sqr_ff  <= sqr_in;
      if (adv[2]) dist_ff <= dist_in;
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_data  = dist_ff;

endmodule

// ===== sv/ppg_isqrt.sv =====
// ----------------------------------------------------------------------------
// ppg_isqrt
// Pipelined floor integer square root of the squared radius, two
// restoring steps per stage.
// ----------------------------------------------------------------------------
module ppg_isqrt import ppg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ppg_dist_type  in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output ppg_polar_type out_data
);

   localparam int STAGES = (ROOT_W + 1) / 2;
   localparam int RW     = 2 * ROOT_W + 1;

   typedef struct packed {
      logic [RW-1:0]      rem;
      logic [RW-1:0]      root;
      logic [COORD_W-1:0] xq;
      logic [COORD_W-1:0] yq;
   } sq_stage_type;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES:0]   adv;
   sq_stage_type      stg_ff  [STAGES];
   sq_stage_type      stg_in  [STAGES];
   sq_stage_type      src     [STAGES];

   always_comb begin
      adv[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_comb begin
      sq_stage_type      cur;
      logic [RW-1:0]     bit_v;
      logic [RW-1:0]     trial;
      int                j;
      src[0].rem  = RW'(in_data.dist_sq);
      src[0].root = '0;
      src[0].xq   = in_data.xq;
      src[0].yq   = in_data.yq;
      for (int k = 1; k < STAGES; k++) begin
         src[k] = stg_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         cur = src[k];
         for (int i = 0; i < 2; i++) begin
            j = 2 * k + i;
            if (j < ROOT_W) begin
               bit_v = RW'(1) << (2 * (ROOT_W - 1 - j));
               trial = cur.root + bit_v;
               if (cur.rem >= trial) begin
                  cur.rem  = cur.rem - trial;
                  cur.root = (cur.root >> 1) + bit_v;
               end else begin
                  cur.root = cur.root >> 1;
               end
            end
         end
         stg_in[k] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) stg_ff[k] <= stg_in[k];
      end
   end

   assign in_ready        = adv[0];
   assign out_valid       = vld_ff[STAGES-1];
   assign out_data.xq     = stg_ff[STAGES-1].xq;
   assign out_data.yq     = stg_ff[STAGES-1].yq;
   assign out_data.radius = stg_ff[STAGES-1].root[ROOT_W-1:0];

endmodule

// ===== sv/ppg_wave.sv =====
// ----------------------------------------------------------------------------
// ppg_wave
// Forms the four wave phases, looks up and interpolates the sines, and
// sums them into a saturated Q14 shade. Five stages.
// ----------------------------------------------------------------------------
module ppg_wave import ppg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [TIME_W-1:0]  frame_time,
   input  logic               in_valid,
   output logic               in_ready,
   input  ppg_polar_type      in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [SHADE_W-1:0] out_shade
);

   localparam int STAGES = 5;
   // Lanes whose time term is subtracted
   localparam logic [NUM_WAVES-1:0] TIME_SUB = 4'b1010;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES:0]   adv;

   logic [PHASE_W-1:0]       sprod_ff [NUM_WAVES];
   logic [PHASE_W-1:0]       sprod_in [NUM_WAVES];
   logic [PHASE_W-1:0]       tprod_ff [NUM_WAVES];
   logic [PHASE_W-1:0]       tprod_in [NUM_WAVES];
   logic [PHASE_W-1:0]       phase_ff [NUM_WAVES];
   logic [PHASE_W-1:0]       phase_in [NUM_WAVES];
   logic [MAG_W-1:0]         base_ff  [NUM_WAVES];
   logic [MAG_W-1:0]         base_in  [NUM_WAVES];
   logic [MAG_W-1:0]         diff_ff  [NUM_WAVES];
   logic [MAG_W-1:0]         diff_in  [NUM_WAVES];
   logic [10:0]              frac_ff  [NUM_WAVES];
   logic [10:0]              frac_in  [NUM_WAVES];
   logic [NUM_WAVES-1:0]     neg_ff, neg_in;
   logic signed [WAVE_W-1:0] wave_ff  [NUM_WAVES];
   logic signed [WAVE_W-1:0] wave_in  [NUM_WAVES];
   logic [SHADE_W-1:0]       shade_ff, shade_in;

   always_comb begin
      adv[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   // Phase products, kept modulo one turn
   always_comb begin
      sprod_in[0] = PHASE_W'(in_data.xq) * KX_12;
      sprod_in[1] = PHASE_W'(in_data.yq) * KY_9;
      sprod_in[2] = (PHASE_W'(in_data.xq) + PHASE_W'(in_data.yq)) * KXY_7;
      sprod_in[3] = PHASE_W'(in_data.radius) * KR_24;
      tprod_in[0] = PHASE_W'(frame_time) * KT_1;
      tprod_in[1] = PHASE_W'(frame_time) * KT_07;
      tprod_in[2] = PHASE_W'(frame_time) * KT_13;
      tprod_in[3] = PHASE_W'(frame_time) * KT_2;
   end

   always_comb begin
      for (int l = 0; l < NUM_WAVES; l++) begin
         phase_in[l] = TIME_SUB[l] ? sprod_ff[l] - tprod_ff[l]
                                   : sprod_ff[l] + tprod_ff[l];
      end
   end

   // Table lookup: fold the quadrant, pick segment and fraction
   always_comb begin
      logic [16:0] w;
      logic [5:0]  idx;
      for (int l = 0; l < NUM_WAVES; l++) begin
         w = {1'b0, phase_ff[l][29:14]};
         if (phase_ff[l][30]) w = 17'h10000 - w;
         idx        = w[16:11];
         frac_in[l] = w[10:0];
         neg_in[l]  = phase_ff[l][31];
         if (idx >= 6'd32) begin
            base_in[l] = QUARTER_SINE[32];
            diff_in[l] = '0;
         end else begin
            base_in[l] = QUARTER_SINE[idx];
            diff_in[l] = QUARTER_SINE[idx + 6'd1] - QUARTER_SINE[idx];
         end
      end
   end

   // Linear interpolation and sign
   always_comb begin
      logic [25:0]      prod;
      logic [MAG_W-1:0] mag;
      for (int l = 0; l < NUM_WAVES; l++) begin
         prod = 26'(diff_ff[l]) * 26'(frac_ff[l]);
         mag  = base_ff[l] + MAG_W'(prod >> 11);
         wave_in[l] = neg_ff[l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   // Sum, bias and saturate
   always_comb begin
      logic signed [18:0] biased;
      logic [15:0]        s;
      biased = 19'sd65536;
      for (int l = 0; l < NUM_WAVES; l++) begin
         biased = biased + 19'(wave_ff[l]);
      end
      if (biased < 0) biased = '0;
      s = biased[18:3];
      shade_in = (s > 16'(ONE_Q14)) ? ONE_Q14 : s[SHADE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (adv[0]) begin
         sprod_ff <= sprod_in;
         tprod_ff <= tprod_in;
      end
      if (adv[1]) phase_ff <= phase_in;
      if (adv[2]) begin
         base_ff <= base_in;
         diff_ff <= diff_in;
         frac_ff <= frac_in;
         neg_ff  <= neg_in;
      end
      if (adv[3]) wave_ff  <= wave_in;
      if (adv[4]) shade_ff <= shade_in;
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_shade = shade_ff;

endmodule

// ===== sv/ppg_color.sv =====
// ----------------------------------------------------------------------------
// ppg_color
// Blends the cool and warm endpoints by the shade and rounds each channel
// to 8 bits. Two stages; the last is the output register.
// ----------------------------------------------------------------------------
module ppg_color import ppg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [SHADE_W-1:0] in_shade,
   output logic               out_valid,
   input  logic               out_ready,
   output ppg_rsp_type        out_data
);

   localparam int STAGES = 2;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [STAGES:0]   adv;
   logic [30:0]       mix_ff [3];
   logic [30:0]       mix_in [3];
   logic [7:0]        chan_in [3];
   ppg_rsp_type       rsp_ff, rsp_in;

   always_comb begin
      adv[STAGES] = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_in[c] = 31'(COOL_Q16[c]) * 31'(ONE_Q14 - in_shade)
                   + 31'(WARM_Q16[c]) * 31'(in_shade);
      end
   end

   // Scale by 255 and round half up
   always_comb begin
      logic [39:0] scaled;
      logic [9:0]  o;
      for (int c = 0; c < 3; c++) begin
         scaled = ({9'b0, mix_ff[c]} << 8) - 40'(mix_ff[c]) + 40'(1 << 29);
         o = scaled[39:30];
         chan_in[c] = (o > 10'd255) ? 8'd255 : o[7:0];
      end
      rsp_in.red   = chan_in[0];
      rsp_in.green = chan_in[1];
      rsp_in.blue  = chan_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (adv[0]) mix_ff <= mix_in;
      if (adv[1]) rsp_ff <= rsp_in;
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[STAGES-1];
   assign out_data  = rsp_ff;

endmodule

// ===== sv/plasma_pixel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// plasma_pixel_generator_unit
// Procedural plasma texture: one pixel coordinate in, one 8-bit RGB out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one pixel coordinate per transaction (valid/ready).
//   rsp_*  carries the shaded RGB for it, in the same order (valid/ready).
//   csr_*  writes frame_time (unsigned Q8.16 seconds); csr_ready is always
//          high. Write it only between frames while the pipeline is empty.
// Throughput: one transaction per cycle while rsp_ready stays high.
// Stages from req acceptance to rsp_valid: 3 coordinate and distance
//   stages, 9 square-root stages (two root bits per stage), 5 wave
//   stages and 2 color stages, the last being the output register.
// Reset (synchronous, active high) empties every stage and clears
//   frame_time to zero.
// Stall: when rsp_ready is low the result holds; stages behind it keep
//   filling bubbles, and req_ready drops only once every stage holds a
//   transaction. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_unit import ppg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppg_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ppg_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TIME_W-1:0] csr_data
);

   logic [TIME_W-1:0]  frame_time_ff, frame_time_in;

   logic               dist_valid, dist_ready;
   ppg_dist_type       dist_data;
   logic               polar_valid, polar_ready;
   ppg_polar_type      polar_data;
   logic               shade_valid, shade_ready;
   logic [SHADE_W-1:0] shade;

   // Frame time register: take every csr transaction
   assign csr_ready     = 1'b1;
   assign frame_time_in = csr_valid ? csr_data : frame_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= '0;
      end else begin
         frame_time_ff <= frame_time_in;
      end
   end

   // Normalize and square the offset from the center
   ppg_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_data  (dist_data)
   );

   // Radius from the squared distance
   ppg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_ready  (dist_ready),
      .in_data   (dist_data),
      .out_valid (polar_valid),
      .out_ready (polar_ready),
      .out_data  (polar_data)
   );

   // Four travelling waves summed into a shade
   ppg_wave u_wave (
      .clock      (clock),
      .reset      (reset),
      .frame_time (frame_time_ff),
      .in_valid   (polar_valid),
      .in_ready   (polar_ready),
      .in_data    (polar_data),
      .out_valid  (shade_valid),
      .out_ready  (shade_ready),
      .out_shade  (shade)
   );

   // Blend the endpoints and drive the result register
   ppg_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shade_valid),
      .in_ready  (shade_ready),
      .in_shade  (shade),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
